// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the open list table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/aolt_pkg.sv =====
// Package with types, constants and helpers of the open list table.
`timescale 1ns / 1ps

package aolt_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SUM_W-1:0] CEILING_RESET = 17'd255;

  // Operation codes.
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_EXISTS  = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_POP_MIN = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // Register index, taken from address bit 2.
  localparam logic REG_CEILING = 1'b0;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] node_x;
    logic [15:0] node_y;
    logic [15:0] cost_so_far;
    logic [15:0] cost_estimate;
    logic [15:0] parent_x;
    logic [15:0] parent_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_g;
    logic [15:0] out_h;
    logic [15:0] out_parent_x;
    logic [15:0] out_parent_y;
    logic [6:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] g;
    logic [15:0] h;
    logic [15:0] px;
    logic [15:0] py;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Total cost g+h of a stored entry, formed wide enough never to wrap.
  function automatic logic [SUM_W-1:0] cost_sum(entry_t e);
    return {1'b0, e.g} + {1'b0, e.h};
  endfunction

endpackage

// ===== rtl/core/aolt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module aolt_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/astar_open_list_table_unit.sv =====
// Top level of the open list table of an A* search, with its sequencer and entry RAM.
`timescale 1ns / 1ps
// The table holds up to CAPACITY search nodes in insertion order in one RAM.
// An operation arrives as one transfer on the input channel (valid/stall) and
// produces exactly one result transfer on the output channel. The input stalls
// from the cycle after an operation is taken until its result has been placed
// in the output register; the output register then holds it until the
// receiver takes it, while the next operation may already be taken.
// Push, a full push, pop_min on an empty table and unknown codes go straight
// to the result state. Exists and update scan all entries, one RAM read per
// cycle. Remove and pop_min scan the same way and then close the gap by
// moving each later entry down one place, one per cycle. The single RAM read
// port sets this pace. Reset empties the table (the count goes to zero; the
// RAM itself is not cleared) and sets the pop_min ceiling to 255. The
// ceiling is written over the APB port at byte address 0; the user must
// write it only while the block is idle, which the block does not enforce.
// A stalled receiver holds the finished result in the output register; a
// further result waits in the sequencer until the register is free.

module astar_open_list_table_unit
  import aolt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  state_e           state_q;
  logic [2:0]       op_q;
  logic [15:0]      x_q;
  logic [15:0]      y_q;
  logic [15:0]      new_g_q;
  logic [15:0]      new_h_q;
  logic [SUM_W-1:0] new_sum_q;
  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] ceiling_q;
  logic [CNT_W-1:0] issue_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] hit_idx_q;
  entry_t           hit_q;
  logic [SUM_W-1:0] min_q;
  logic [1:0]       res_status_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic               accept;
  logic               issue_go;
  logic               scan_done;
  logic               coord_hit;
  logic [SUM_W-1:0]   rd_sum;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               cfg_write;
  logic               resp_fire;
  out_item_t          out_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reads are issued in order from issue_q; data returns in the next cycle and
  // is tagged by pend_q and pend_idx_q.
  assign issue_go  = (issue_q < count_q);
  assign scan_done = !issue_go && !pend_q;
  assign rd_entry  = entry_t'(ram_rdata);
  assign rd_sum    = cost_sum(rd_entry);
  assign coord_hit = (rd_entry.x == x_q) && (rd_entry.y == y_q);

  // The single write port serves a push, the rewrite of an updated entry and
  // each step of the gap closing move.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = '{x: in_data_i.node_x, y: in_data_i.node_y,
                  g: in_data_i.cost_so_far, h: in_data_i.cost_estimate,
                  px: in_data_i.parent_x, py: in_data_i.parent_y};
    case (state_q)
      ST_IDLE: begin
        ram_we = accept && (in_data_i.operation == OP_PUSH) &&
                 (count_q < CNT_W'(CAPACITY));
      end
      ST_SCAN: begin
        ram_we    = scan_done && found_q && (op_q == OP_UPDATE);
        ram_waddr = hit_idx_q;
        ram_wdata = '{x: hit_q.x, y: hit_q.y, g: new_g_q, h: new_h_q,
                      px: hit_q.px, py: hit_q.py};
      end
      ST_SHIFT: begin
        ram_we    = pend_q;
        ram_waddr = pend_idx_q - 1'b1;
        ram_wdata = rd_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  aolt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(issue_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Configuration port: one register, the pop_min search ceiling.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CEILING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceiling_q <= CEILING_RESET;
    end else if (cfg_write) begin
      ceiling_q <= pwdata[SUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CEILING) begin
      prdata = CFG_DATA_W'(ceiling_q);
    end
  end

  // The result leaves the sequencer when the output register is empty or is
  // being taken in the same cycle. Only remove and pop_min report an entry.
  assign resp_fire = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d           = '0;
    out_d.status    = res_status_q;
    out_d.occupancy = OCC_W'(count_q);
    if ((res_status_q == STAT_OK) &&
        ((op_q == OP_REMOVE) || (op_q == OP_POP_MIN))) begin
      out_d.out_x        = hit_q.x;
      out_d.out_y        = hit_q.y;
      out_d.out_g        = hit_q.g;
      out_d.out_h        = hit_q.h;
      out_d.out_parent_x = hit_q.px;
      out_d.out_parent_y = hit_q.py;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_PUSH;
      x_q          <= '0;
      y_q          <= '0;
      new_g_q      <= '0;
      new_h_q      <= '0;
      new_sum_q    <= '0;
      count_q      <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      hit_q        <= '0;
      min_q        <= '0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (resp_fire) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q       <= in_data_i.operation;
            x_q        <= in_data_i.node_x;
            y_q        <= in_data_i.node_y;
            new_g_q    <= in_data_i.cost_so_far;
            new_h_q    <= in_data_i.cost_estimate;
            new_sum_q  <= {1'b0, in_data_i.cost_so_far} + {1'b0, in_data_i.cost_estimate};
            issue_q    <= '0;
            pend_q     <= 1'b0;
            found_q    <= 1'b0;
            min_q      <= ceiling_q;
            case (in_data_i.operation)
              OP_PUSH: begin
                if (count_q < CNT_W'(CAPACITY)) begin
                  count_q      <= count_q + 1'b1;
                  res_status_q <= STAT_OK;
                end else begin
                  res_status_q <= STAT_FULL;
                end
                state_q <= ST_RESP;
              end
              OP_EXISTS, OP_REMOVE, OP_UPDATE: begin
                state_q <= ST_SCAN;
              end
              OP_POP_MIN: begin
                if (count_q == '0) begin
                  res_status_q <= STAT_EMPTY;
                  state_q      <= ST_RESP;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              default: begin
                res_status_q <= STAT_MISS;
                state_q      <= ST_RESP;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (issue_go) begin
            issue_q <= issue_q + 1'b1;
          end
          pend_q     <= issue_go;
          pend_idx_q <= issue_q[IDX_W-1:0];

          if (pend_q) begin
            case (op_q)
              OP_POP_MIN: begin
                // A strictly smaller sum restarts the search for the first
                // entry at the minimum; an equal sum counts only if none found.
                if (rd_sum < min_q) begin
                  min_q     <= rd_sum;
                  found_q   <= 1'b1;
                  hit_idx_q <= pend_idx_q;
                  hit_q     <= rd_entry;
                end else if ((rd_sum == min_q) && !found_q) begin
                  found_q   <= 1'b1;
                  hit_idx_q <= pend_idx_q;
                  hit_q     <= rd_entry;
                end
              end
              OP_UPDATE: begin
                if (!found_q && coord_hit && (new_sum_q < rd_sum)) begin
                  found_q   <= 1'b1;
                  hit_idx_q <= pend_idx_q;
                  hit_q     <= rd_entry;
                end
              end
              default: begin
                if (!found_q && coord_hit) begin
                  found_q   <= 1'b1;
                  hit_idx_q <= pend_idx_q;
                  hit_q     <= rd_entry;
                end
              end
            endcase
          end

          if (scan_done) begin
            if (found_q && ((op_q == OP_REMOVE) || (op_q == OP_POP_MIN))) begin
              issue_q <= CNT_W'(hit_idx_q) + 1'b1;
              state_q <= ST_SHIFT;
            end else begin
              res_status_q <= found_q ? STAT_OK : STAT_MISS;
              state_q      <= ST_RESP;
            end
          end
        end

        ST_SHIFT: begin
          if (issue_go) begin
            issue_q <= issue_q + 1'b1;
          end
          pend_q     <= issue_go;
          pend_idx_q <= issue_q[IDX_W-1:0];
          if (scan_done) begin
            count_q      <= count_q - 1'b1;
            res_status_q <= STAT_OK;
            state_q      <= ST_RESP;
          end
        end

        ST_RESP: begin
          if (resp_fire) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The table never holds more entries than it has room for.
  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")

  // Closing the gap only starts from an entry that the scan found in the table.
  `ASSERT_IMPLIES(a_shift_has_hit, state_q == ST_SHIFT, found_q && (CNT_W'(hit_idx_q) < count_q),
                  "gap closing without a valid hit")

  // Each move during gap closing lands below the last occupied place.
  `ASSERT_IMPLIES(a_shift_addr, ram_we && (state_q == ST_SHIFT),
                  (CNT_W'(ram_waddr) + 1'b1) < count_q, "gap closing write out of range")

  // A new result appears only as the sequencer leaves its result state.
  `ASSERT_IMPLIES(a_result_source, $rose(out_valid_q), $past(state_q) == ST_RESP,
                  "result presented outside the result state")

endmodule

// ===== tb/astar_open_list_table_unit_test.sv =====
// Self-checking testbench for the A* open list table unit.
`timescale 1ns / 1ps

module astar_open_list_table_unit_test
  import aolt_pkg::*;
();

  // Operation codes that the block does not define. It must answer them with a miss.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  // Byte address of the ceiling register. The register index sits in address bit 2.
  localparam logic [CFG_ADDR_W-1:0] CEILING_ADDR = {REG_CEILING, 2'b00};

  // Receiver hold-off, in cycles. It is long enough that the block fills up and stalls its
  // input while the sender keeps offering operations.
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AT_RESULT = 150;

  // Settle time after the last result, long enough for a remove or pop_min on a full table.
  localparam int unsigned SETTLE_CYCLES = 2 * CAPACITY + 40;

  // The scoreboard keeps its own copy of the table and of the ceiling register. It also holds
  // the results that are still expected, in order.
  class open_list_scoreboard;
    entry_t      nodes[$];
    logic [16:0] ceiling;
    out_item_t   awaited_results[$];
    int unsigned error_count;

    function new();
      ceiling     = CEILING_RESET;
      error_count = 0;
    endfunction

    function void set_ceiling(logic [16:0] value);
      ceiling = value;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function logic [16:0] node_cost(entry_t n);
      return {1'b0, n.g} + {1'b0, n.h};
    endfunction

    // Index of the first node at (x, y), or -1 if there is none.
    function int find_node(logic [15:0] x, logic [15:0] y);
      foreach (nodes[i]) begin
        if (nodes[i].x == x && nodes[i].y == y) begin
          return i;
        end
      end
      return -1;
    endfunction

    function void take_out(int idx, ref out_item_t res);
      entry_t n;
      n = nodes[idx];
      nodes.delete(idx);
      res.status       = STAT_OK;
      res.out_x        = n.x;
      res.out_y        = n.y;
      res.out_g        = n.g;
      res.out_h        = n.h;
      res.out_parent_x = n.px;
      res.out_parent_y = n.py;
    endfunction

    // Applies one operation to the table copy and returns the result that the block must give.
    function out_item_t table_response(in_item_t op);
      out_item_t   res;
      int          hit;
      logic [16:0] best;
      logic [16:0] new_cost;
      res        = '0;
      res.status = STAT_MISS;
      hit        = -1;
      case (op.operation)
        OP_PUSH: begin
          if (nodes.size() >= CAPACITY) begin
            res.status = STAT_FULL;
          end else begin
            nodes.push_back(entry_t'{x: op.node_x, y: op.node_y, g: op.cost_so_far,
                                     h: op.cost_estimate, px: op.parent_x, py: op.parent_y});
            res.status = STAT_OK;
          end
        end
        OP_EXISTS: begin
          if (find_node(op.node_x, op.node_y) >= 0) begin
            res.status = STAT_OK;
          end
        end
        OP_REMOVE: begin
          hit = find_node(op.node_x, op.node_y);
          if (hit >= 0) begin
            take_out(hit, res);
          end
        end
        OP_POP_MIN: begin
          if (nodes.size() == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            // The search starts at the ceiling. When every sum lies above it, nothing
            // matches and the table is left alone.
            best = ceiling;
            foreach (nodes[i]) begin
              if (node_cost(nodes[i]) < best) begin
                best = node_cost(nodes[i]);
              end
            end
            foreach (nodes[i]) begin
              if (hit < 0 && node_cost(nodes[i]) == best) begin
                hit = i;
              end
            end
            if (hit >= 0) begin
              take_out(hit, res);
            end
          end
        end
        OP_UPDATE: begin
          new_cost = {1'b0, op.cost_so_far} + {1'b0, op.cost_estimate};
          foreach (nodes[i]) begin
            if (hit < 0 && nodes[i].x == op.node_x && nodes[i].y == op.node_y &&
                new_cost < node_cost(nodes[i])) begin
              nodes[i].g = op.cost_so_far;
              nodes[i].h = op.cost_estimate;
              res.status = STAT_OK;
              hit        = i;
            end
          end
        end
        default: begin
        end
      endcase
      res.occupancy = 7'(nodes.size());
      return res;
    endfunction

    function void note_operation(in_item_t op);
      awaited_results.push_back(table_response(op));
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no operation outstanding: %0h", got);
        error_count++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_g", want.out_g, got.out_g);
      compare_field("out_h", want.out_h, got.out_h);
      compare_field("out_parent_x", want.out_parent_x, got.out_parent_x);
      compare_field("out_parent_y", want.out_parent_y, got.out_parent_y);
      compare_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  open_list_scoreboard sb = new();
  int unsigned         sent_count;
  int unsigned         received_count;

  astar_open_list_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The sender is called at a falling edge and returns at the falling edge after the transfer.
  // Valid drops only when a gap is drawn, so back-to-back operations keep it high. Every fourth
  // block of 64 operations is sent with no gaps at all.
  task automatic send_op(input in_item_t op);
    int unsigned gap;
    gap = ((sent_count / 64) % 4 == 1) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= op;
    in_valid_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_operation(op);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Lowers valid and waits until every expected result has been taken. A few spare cycles
  // follow, so that the block is idle before the next register access.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes the ceiling with a setup and an access cycle, then reads it back the same way.
  task automatic program_ceiling(input logic [16:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CEILING_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_ceiling(value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== CFG_DATA_W'(value)) begin
      $error("min_search_ceiling: expected %0h, got %0h", value, prdata);
      sb.error_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic in_item_t make_op(logic [2:0] code, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] g, logic [15:0] h,
                                       logic [15:0] px, logic [15:0] py);
    in_item_t op;
    op.operation     = code;
    op.node_x        = x;
    op.node_y        = y;
    op.cost_so_far   = g;
    op.cost_estimate = h;
    op.parent_x      = px;
    op.parent_y      = py;
    return op;
  endfunction

  // Coordinates mostly come from a small set, 0 to 3 and their complements, so that exists,
  // remove and update often find a match. Now and then a coordinate is fully random.
  function automatic logic [15:0] pick_coord();
    logic [15:0] c;
    if ($urandom_range(0, 9) == 0) begin
      c = 16'($urandom);
    end else begin
      c = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) c = ~c;
    end
    return c;
  endfunction

  // Costs are mostly small, so that the sums gather around the default ceiling. Now and then a
  // cost is drawn from the full range.
  function automatic logic [15:0] pick_cost();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
  endfunction

  // push_pct sets the share of pushes. The rest is spread over the other operations, with a
  // few unused codes mixed in.
  task automatic run_random(input int unsigned count, input int unsigned push_pct);
    in_item_t    op;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        op.operation = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (pick < 3 + push_pct) begin
        op.operation = OP_PUSH;
      end else begin
        case ($urandom_range(0, 3))
          0:       op.operation = OP_EXISTS;
          1:       op.operation = OP_REMOVE;
          2:       op.operation = OP_POP_MIN;
          default: op.operation = OP_UPDATE;
        endcase
      end
      op.node_x        = pick_coord();
      op.node_y        = pick_coord();
      op.cost_so_far   = pick_cost();
      op.cost_estimate = pick_cost();
      op.parent_x      = 16'($urandom);
      op.parent_y      = 16'($urandom);
      send_op(op);
    end
  endtask

  // The receiver draws a random stall after each transfer, with stretches of no
  // stall at all. After HOLD_AT_RESULT results it holds off for a long time, so that the
  // output register and the sequencer both fill up and the input stalls.
  initial begin : result_receiver
    int unsigned hold;
    out_stall_i    = 1'b0;
    received_count = 0;
    hold           = 0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        received_count++;
        if (received_count == HOLD_AT_RESULT) begin
          hold = LONG_HOLD;
        end else if ((received_count / 64) % 4 == 3) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 7);
        end
      end
    end
  end

  // The run ends here if the block hangs.
  initial begin : watchdog
    #(5_000_000);
    $display("astar_open_list_table_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    sent_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with the ceiling at its reset value of 255. An empty table answers every
    // lookup with a miss, and pop_min with empty.
    send_op(make_op(OP_POP_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_EXISTS, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_REMOVE, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_UPDATE, 16'h0005, 16'h0007, 16'h0001, 16'h0001, 16'h0000, 16'h0000));
    // Field extremes: all zeros, then all ones. The latter is the largest sum, 131070,
    // which must not wrap.
    send_op(make_op(OP_PUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // Two nodes at the same coordinates. Lookups must pick the first of them.
    send_op(make_op(OP_PUSH, 16'h0005, 16'h0007, 16'd100, 16'd100, 16'h0001, 16'h0002));
    send_op(make_op(OP_PUSH, 16'h0005, 16'h0007, 16'd10, 16'd10, 16'hA5A5, 16'h5A5A));
    send_op(make_op(OP_EXISTS, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_EXISTS, 16'h0007, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // An update that lowers no sum is refused. The next one lowers the first match and must
    // leave its parent untouched.
    send_op(make_op(OP_UPDATE, 16'h0005, 16'h0007, 16'd200, 16'd200, 16'h1111, 16'h2222));
    send_op(make_op(OP_UPDATE, 16'h0005, 16'h0007, 16'd50, 16'd50, 16'h3333, 16'h4444));
    send_op(make_op(OP_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0000, 16'h0000));
    send_op(make_op(OP_UNUSED_FIRST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000));
    send_op(make_op(OP_UNUSED_FIRST + 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF));
    send_op(make_op(OP_UNUSED_LAST, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000));
    send_op(make_op(OP_POP_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_POP_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_REMOVE, 16'h0005, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Only the all-ones node is left, and its sum lies far above the ceiling, so pop_min
    // finds nothing.
    send_op(make_op(OP_POP_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_op(make_op(OP_POP_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // With the ceiling at its maximum, pop_min removes something whenever the table holds
    // a node. The long receiver hold-off falls in this phase.
    program_ceiling(17'h1FFFF);
    run_random(170, 45);
    drain();

    // Mostly pushes, so that the table fills and full pushes are refused. With a ceiling of
    // zero, pop_min removes only nodes whose sum is zero.
    program_ceiling(17'h00000);
    run_random(140, 80);
    drain();

    // A ceiling of middling size, with few pushes, so that the table drains again.
    program_ceiling(17'($urandom_range(100, 400)));
    run_random(200, 30);
    drain();

    program_ceiling(CEILING_RESET);
    run_random(140, 40);
    drain();

    // Give a late extra result time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("astar_open_list_table_unit: match");
    end else begin
      $display("astar_open_list_table_unit: mismatch");
    end
    $finish;
  end

endmodule
